@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NRSD_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define NRSD_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/nrsd_pkg.sv @@
// ---------------------------------------------------------------------------
// nrsd_pkg
// Types and constants of the nested reply stream deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrsd_pkg;

	// Result status codes
	localparam logic [1:0] ST_PAYLOAD = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;

	// Reply family codes
	localparam logic [1:0] FAM_S_LOW  = 2'd0;
	localparam logic [1:0] FAM_E      = 2'd1;
	localparam logic [1:0] FAM_S_HIGH = 2'd2;

	// Header characters
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
	localparam logic [7:0] CH_STAR  = 8'h2a;  // '*'
	localparam logic [7:0] CH_SLOW  = 8'h73;  // 's'
	localparam logic [7:0] CH_E     = 8'h65;  // 'e'
	localparam logic [7:0] CH_SHIGH = 8'h53;  // 'S'

	localparam logic [2:0] HDR_LEN  = 3'd5;
	localparam logic [2:0] HDR_HELD = 3'd4;

	// Result queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] payload_byte;
		logic       reply_kind;
		logic [1:0] reply_family;
		logic [7:0] reply_token;
		logic [9:0] payload_length;
		logic       last_of_reply;
		logic       at_boundary;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ rtl/nrsd_queue.sv @@
// ---------------------------------------------------------------------------
// nrsd_queue
// Short result FIFO decoupling the parser front from the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nrsd_pkg::res_t    wr_data,
	input  logic              pop,
	output nrsd_pkg::res_t    rd_data,
	output nrsd_pkg::q_stat_t stat
);

	localparam logic [nrsd_pkg::QPTR_W:0] FullCnt = (nrsd_pkg::QPTR_W + 1)'(nrsd_pkg::QUEUE_DEPTH);

	nrsd_pkg::res_t              mem_q [nrsd_pkg::QUEUE_DEPTH];
	logic [nrsd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [nrsd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [nrsd_pkg::QPTR_W:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == FullCnt);
	assign stat.empty = (cnt_q == '0);

endmodule

@@ rtl/nrsd_front.sv @@
// ---------------------------------------------------------------------------
// nrsd_front
// Byte intake: outer frame tracking, reply header check, result building.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrsd_front #(
	parameter int OUTER_MAX = 4096,
	parameter int REPLY_MAX = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        rx_byte,
	output logic              in_stall,
	input  nrsd_pkg::q_stat_t q_stat,
	output logic              push,
	output nrsd_pkg::res_t    res
);

	localparam logic [16:0] OuterMax = 17'(OUTER_MAX);
	localparam logic [16:0] BodyMax  = 17'(REPLY_MAX - 5);

	logic        failed_q;
	logic [15:0] outer_cnt_q;
	logic [15:0] outer_tot_q;
	logic [2:0]  hdr_cnt_q;
	logic [7:0]  hdr_q [4];
	logic [15:0] body_len_q;
	logic [15:0] body_cnt_q;
	logic [7:0]  token_q;

	logic        failed_n;
	logic [15:0] outer_cnt_n;
	logic [15:0] outer_tot_n;
	logic [2:0]  hdr_cnt_n;
	logic        hdr_we;
	logic [15:0] body_len_n;
	logic [15:0] body_cnt_n;
	logic [7:0]  token_n;
	logic        emit;

	logic        take;
	logic        kind_star;
	logic [1:0]  fam;
	logic        fam_ok;
	logic [15:0] body;
	logic        hdr_ok;
	logic [15:0] tot;
	logic [15:0] oc;
	logic [15:0] bc;
	logic        last;
	logic [15:0] plen;

	assign in_stall = q_stat.full;
	assign take     = in_valid && !q_stat.full;
	assign push     = take && emit;

	// Decoded header fields
	always_comb begin
		kind_star = (hdr_q[1] == nrsd_pkg::CH_STAR);
		unique case (hdr_q[2])
			nrsd_pkg::CH_E:     fam = nrsd_pkg::FAM_E;
			nrsd_pkg::CH_SHIGH: fam = nrsd_pkg::FAM_S_HIGH;
			default:            fam = nrsd_pkg::FAM_S_LOW;
		endcase
		fam_ok = (hdr_q[2] == nrsd_pkg::CH_SLOW) || (hdr_q[2] == nrsd_pkg::CH_E)
			|| (hdr_q[2] == nrsd_pkg::CH_SHIGH);
		body   = {rx_byte, hdr_q[3]};
		hdr_ok = (hdr_q[0] == nrsd_pkg::CH_ESC)
			&& ((hdr_q[1] == nrsd_pkg::CH_BANG) || kind_star)
			&& fam_ok
			&& !(kind_star && (hdr_q[2] != nrsd_pkg::CH_SLOW))
			&& (body != 16'd0) && ({1'b0, body} <= BodyMax)
			&& !((hdr_q[2] == nrsd_pkg::CH_E) && (body != 16'd2));
		plen = (fam == nrsd_pkg::FAM_E) ? body_len_q : body_len_q - 16'd1;
	end

	always_comb begin
		failed_n    = failed_q;
		outer_cnt_n = outer_cnt_q;
		outer_tot_n = outer_tot_q;
		hdr_cnt_n   = hdr_cnt_q;
		hdr_we      = 1'b0;
		body_len_n  = body_len_q;
		body_cnt_n  = body_cnt_q;
		token_n     = token_q;
		emit        = 1'b0;
		res         = '0;
		tot         = {outer_tot_q[15:8], rx_byte};
		oc          = outer_cnt_q + 16'd1;
		bc          = body_cnt_q + 16'd1;
		last        = (bc >= body_len_q);

		if (failed_q) begin
			emit       = 1'b1;
			res.status = nrsd_pkg::ST_FAIL;
		end else if (outer_cnt_q == 16'd0) begin
			outer_tot_n = {rx_byte, 8'h00};
			outer_cnt_n = 16'd1;
		end else if (outer_cnt_q == 16'd1) begin
			if ((tot < 16'd2) || ({1'b0, tot} > OuterMax)) begin
				failed_n   = 1'b1;
				emit       = 1'b1;
				res.status = nrsd_pkg::ST_FAIL;
			end else begin
				outer_tot_n = tot;
				outer_cnt_n = (tot == 16'd2) ? 16'd0 : 16'd2;
			end
		end else begin
			outer_cnt_n = (oc >= outer_tot_q) ? 16'd0 : oc;
			if (hdr_cnt_q < nrsd_pkg::HDR_HELD) begin
				hdr_we    = 1'b1;
				hdr_cnt_n = hdr_cnt_q + 3'd1;
			end else if (hdr_cnt_q == nrsd_pkg::HDR_HELD) begin
				if (!hdr_ok) begin
					failed_n   = 1'b1;
					emit       = 1'b1;
					res.status = nrsd_pkg::ST_FAIL;
				end else begin
					hdr_cnt_n  = nrsd_pkg::HDR_LEN;
					body_len_n = body;
					body_cnt_n = 16'd0;
					token_n    = 8'h00;
				end
			end else begin
				body_cnt_n = bc;
				if (last) begin
					hdr_cnt_n = 3'd0;
				end
				res.reply_kind     = kind_star;
				res.reply_family   = fam;
				res.payload_length = plen[9:0];
				res.last_of_reply  = last;
				res.at_boundary    = (outer_cnt_n == 16'd0) && last;
				if ((fam != nrsd_pkg::FAM_E) && (bc == 16'd1)) begin
					// token byte: only an empty payload reports it
					token_n         = rx_byte;
					emit            = last;
					res.status      = nrsd_pkg::ST_EMPTY;
					res.reply_token = rx_byte;
				end else begin
					emit             = 1'b1;
					res.status       = nrsd_pkg::ST_PAYLOAD;
					res.payload_byte = rx_byte;
					res.reply_token  = (fam == nrsd_pkg::FAM_E) ? 8'h00 : token_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q    <= 1'b0;
			outer_cnt_q <= '0;
			outer_tot_q <= '0;
			hdr_cnt_q   <= '0;
			hdr_q[0]    <= '0;
			hdr_q[1]    <= '0;
			hdr_q[2]    <= '0;
			hdr_q[3]    <= '0;
			body_len_q  <= '0;
			body_cnt_q  <= '0;
			token_q     <= '0;
		end else if (take) begin
			failed_q    <= failed_n;
			outer_cnt_q <= outer_cnt_n;
			outer_tot_q <= outer_tot_n;
			hdr_cnt_q   <= hdr_cnt_n;
			if (hdr_we) begin
				hdr_q[hdr_cnt_q[1:0]] <= rx_byte;
			end
			body_len_q  <= body_len_n;
			body_cnt_q  <= body_cnt_n;
			token_q     <= token_n;
		end
	end

endmodule

@@ rtl/nrsd_back.sv @@
// ---------------------------------------------------------------------------
// nrsd_back
// Output stage: drains the result queue into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  nrsd_pkg::q_stat_t q_stat,
	input  nrsd_pkg::res_t    q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output nrsd_pkg::res_t    out_res
);

	logic           out_valid_q;
	nrsd_pkg::res_t out_res_q;

	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= q_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

@@ rtl/nested_reply_stream_deframer.sv @@
// ---------------------------------------------------------------------------
// nested_reply_stream_deframer
// Splits a length-framed byte stream into replies and streams their payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   rx_byte
// out      source     out_valid / out_stall status, payload_byte, reply_kind,
//                                           reply_family, reply_token,
//                                           payload_length, last_of_reply,
//                                           at_boundary
//
// One byte per cycle while in_stall is low; a byte that gives a result is
// written to the queue at its beat, then taken into the output register.
// The front only stalls when the four-entry result queue is full, so a stalled
// output side still absorbs up to five results before in_stall rises.
// arst_n clears all framing state, the queue and the output valid.
// Length, header and non-empty reply token bytes beat only on a failure.

module nested_reply_stream_deframer #(
	parameter int OUTER_MAX = 4096,
	parameter int REPLY_MAX = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] payload_byte,
	output logic       reply_kind,
	output logic [1:0] reply_family,
	output logic [7:0] reply_token,
	output logic [9:0] payload_length,
	output logic       last_of_reply,
	output logic       at_boundary
);

	nrsd_pkg::res_t    front_res;
	nrsd_pkg::res_t    q_data;
	nrsd_pkg::res_t    out_res;
	nrsd_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	// Front: frame and header tracking, one byte per beat
	nrsd_front #(
		.OUTER_MAX(OUTER_MAX),
		.REPLY_MAX(REPLY_MAX)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.rx_byte (rx_byte),
		.in_stall(in_stall),
		.q_stat  (q_stat),
		.push    (push),
		.res     (front_res)
	);

	// Result queue decouples intake from output back-pressure
	nrsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(front_res),
		.pop    (pop),
		.rd_data(q_data),
		.stat   (q_stat)
	);

	// Back: registered output beat
	nrsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_data   (q_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign status         = out_res.status;
	assign payload_byte   = out_res.payload_byte;
	assign reply_kind     = out_res.reply_kind;
	assign reply_family   = out_res.reply_family;
	assign reply_token    = out_res.reply_token;
	assign payload_length = out_res.payload_length;
	assign last_of_reply  = out_res.last_of_reply;
	assign at_boundary    = out_res.at_boundary;

endmodule

@@ rtl/nrsd_checker.sv @@
// ---------------------------------------------------------------------------
// nrsd_checker
// Port-level checks of the deframer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nrsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] payload_byte,
	input logic       reply_kind,
	input logic [1:0] reply_family,
	input logic [7:0] reply_token,
	input logic [9:0] payload_length,
	input logic       last_of_reply,
	input logic       at_boundary
);

	logic fail_beat;
	logic empty_beat;

	assign fail_beat  = out_valid && (status == nrsd_pkg::ST_FAIL);
	assign empty_beat = out_valid && (status == nrsd_pkg::ST_EMPTY);

	`NRSD_ASSERT_IMP(a_fail_zero, clk, arst_n, fail_beat, (payload_byte == 8'h00) && !reply_kind && (reply_family == 2'd0) && (reply_token == 8'h00) && (payload_length == 10'd0) && !last_of_reply && !at_boundary, "failure beat carries nonzero fields")
	`NRSD_ASSERT_IMP(a_empty_last, clk, arst_n, empty_beat, last_of_reply && (payload_byte == 8'h00), "empty reply beat not final or has data")
	`NRSD_ASSERT_IMP(a_boundary_last, clk, arst_n, out_valid && at_boundary, last_of_reply, "boundary reported inside a reply")
	`NRSD_ASSERT_NXT(a_fail_sticky, clk, arst_n, fail_beat && !out_stall, !out_valid || (status == nrsd_pkg::ST_FAIL), "stream recovered after failure")
	`NRSD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(payload_byte), "stalled output beat changed")

endmodule

bind nested_reply_stream_deframer nrsd_checker u_nrsd_checker (.*);
